// ----- src/mas_pkg.sv -----
// Shared types and constants for the three-channel moving-average scaler.
// Used by mas_lane, mas_merge and the top level; depends on nothing else.

package mas_pkg;

  // Default generics, handed down from the top level.
  localparam int unsigned WINDOW_DEF      = 8;
  localparam int unsigned SAMPLE_BITS_DEF = 12;

  // Fixed field widths.
  localparam int unsigned NUM_CH  = 3;
  localparam int unsigned AVG_W   = 12;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CIDX_W  = 3;

  // Channel order inside the lane arrays.
  localparam int unsigned CH_INLET  = 0;
  localparam int unsigned CH_OUTLET = 1;
  localparam int unsigned CH_FLOW   = 2;

  // Command codes carried by an input word.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Calibration register map.
  typedef enum logic [CIDX_W-1:0] {
    REG_INLET_SCALE   = 3'd0,
    REG_INLET_OFFSET  = 3'd1,
    REG_OUTLET_SCALE  = 3'd2,
    REG_OUTLET_OFFSET = 3'd3,
    REG_FLOW_SCALE    = 3'd4,
    REG_FLOW_OFFSET   = 3'd5
  } reg_idx_e;

  localparam logic signed [CFG_W-1:0] SCALE_RST  = 32'sd65536;
  localparam logic signed [CFG_W-1:0] OFFSET_RST = 32'sd0;

  // Strobes from the shared pipeline control to every lane.
  typedef struct packed {
    logic acc;  // a word is accepted: read the oldest slot
    logic wr;   // the accepted word is a sample: write it into the ring
    logic upd;  // the running-sum stage retires its word
    logic clr;  // the retiring word is a clear
    logic sub;  // the ring was full: subtract the oldest sample
    logic ld2;  // load the new sum into the divide stage
    logic ld3;  // load the average into the scale stage
    logic ld4;  // load the calibration product
  } lane_ctrl_t;

endpackage

// ----- src/mas_lane.sv -----
// One channel lane: sample ring, running sum, divide by WINDOW and gain multiply.
// Depends on mas_pkg for the control struct.

module mas_lane
  import mas_pkg::*;
#(
  parameter int unsigned WINDOW      = WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int unsigned PTR_W  = $clog2(WINDOW),
  localparam int unsigned PROD_W = SAMPLE_BITS + CFG_W + 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lane_ctrl_t               ctrl_i,
  input  logic [PTR_W-1:0]         slot_i,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  input  logic signed [CFG_W-1:0]  scale_i,
  output logic [SAMPLE_BITS-1:0]   avg_o,
  output logic signed [PROD_W-1:0] prod_o
);

  // Sum width and the reciprocal used for the exact floor divide.
  localparam int unsigned SUM_W   = SAMPLE_BITS + $clog2(WINDOW);
  localparam int unsigned DIV_K   = SUM_W + $clog2(WINDOW);
  localparam int unsigned M_W     = SUM_W + 1;
  localparam int unsigned DPROD_W = SUM_W + M_W;
  localparam longint unsigned DIV_ONE = 64'd1 << DIV_K;
  localparam longint unsigned DIV_MF  = (DIV_ONE + WINDOW - 1) / WINDOW;
  localparam logic [M_W-1:0] DIV_M    = DIV_MF[M_W-1:0];

  logic [SAMPLE_BITS-1:0]   mem_q [WINDOW];
  logic [SAMPLE_BITS-1:0]   rd_q;
  logic [SAMPLE_BITS-1:0]   s1_q;
  logic [SUM_W-1:0]         sum_q;
  logic [SUM_W-1:0]         sum_d;
  logic [SUM_W-1:0]         sumr_q;
  logic [DPROD_W-1:0]       dprod;
  logic [SAMPLE_BITS-1:0]   avg_q;
  logic [SAMPLE_BITS-1:0]   avg4_q;
  logic signed [SAMPLE_BITS:0] avg_s;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;

  // Ring memory: read-first, so the oldest sample comes out as the new one goes in.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc) begin
      rd_q <= mem_q[slot_i];
      s1_q <= sample_i;
      if (ctrl_i.wr) begin
        mem_q[slot_i] <= sample_i;
      end
    end
  end

  // Running sum: add the new sample, drop the oldest once the ring is full.
  always_comb begin
    if (ctrl_i.clr) begin
      sum_d = '0;
    end else begin
      sum_d = sum_q - (ctrl_i.sub ? SUM_W'(rd_q) : '0) + SUM_W'(s1_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl_i.upd) begin
      sum_q <= sum_d;
    end
  end

  // Floor divide by WINDOW as a multiply by the rounded-up reciprocal.
  assign dprod = DPROD_W'(sumr_q) * DPROD_W'(DIV_M);

  // Calibration gain: unsigned average times signed Q16.16 scale.
  assign avg_s  = {1'b0, avg_q};
  assign prod_d = avg_s * scale_i;

  // The average travels with its product into the last stage.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld2) begin
      sumr_q <= sum_d;
    end
    if (ctrl_i.ld3) begin
      avg_q <= dprod[DIV_K +: SAMPLE_BITS];
    end
    if (ctrl_i.ld4) begin
      prod_q <= prod_d;
      avg4_q <= avg_q;
    end
  end

  assign avg_o  = avg4_q;
  assign prod_o = prod_q;

endmodule

// ----- src/mas_merge.sv -----
// Output stage: adds the offsets, saturates and holds the result word for all lanes.
// Depends on mas_pkg for channel count and widths.

module mas_merge
  import mas_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int unsigned PROD_W = SAMPLE_BITS + CFG_W + 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     ld_i,
  input  logic                     out_stall_i,
  output logic                     rdy_o,
  input  logic [SAMPLE_BITS-1:0]   avg_i    [NUM_CH],
  input  logic signed [PROD_W-1:0] prod_i   [NUM_CH],
  input  logic signed [CFG_W-1:0]  offset_i [NUM_CH],
  output logic                     out_valid_o,
  output logic [AVG_W-1:0]         avg_o    [NUM_CH],
  output logic signed [CFG_W-1:0]  phys_o   [NUM_CH]
);

  localparam int unsigned ACC_W = PROD_W + 1;
  localparam logic signed [ACC_W-1:0] SAT_MAX = {{(ACC_W-CFG_W){1'b0}}, 32'h7FFF_FFFF};
  localparam logic signed [ACC_W-1:0] SAT_MIN = {{(ACC_W-CFG_W){1'b1}}, 32'h8000_0000};

  logic                    out_v_q;
  logic signed [ACC_W-1:0] acc     [NUM_CH];
  logic signed [CFG_W-1:0] phys_d  [NUM_CH];
  logic [AVG_W-1:0]        avg_q   [NUM_CH];
  logic signed [CFG_W-1:0] phys_q  [NUM_CH];

  // The output register takes a new word when it is empty or being drained.
  assign rdy_o = !out_v_q || !out_stall_i;

  // Offset add and saturation to the signed 32-bit range, per lane.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      acc[c] = ACC_W'(prod_i[c]) + ACC_W'(offset_i[c]);
      if (acc[c] > SAT_MAX) begin
        phys_d[c] = SAT_MAX[CFG_W-1:0];
      end else if (acc[c] < SAT_MIN) begin
        phys_d[c] = SAT_MIN[CFG_W-1:0];
      end else begin
        phys_d[c] = acc[c][CFG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (rdy_o) begin
      out_v_q <= ld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      for (int c = 0; c < NUM_CH; c++) begin
        avg_q[c]  <= AVG_W'(avg_i[c]);
        phys_q[c] <= phys_d[c];
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign avg_o       = avg_q;
  assign phys_o      = phys_q;

endmodule

// ----- src/three_channel_moving_average_scaler.sv -----
// Three-channel boxcar moving average with a linear Q16.16 calibration per channel.
// One input word carries an inlet, outlet and flow sample; each channel runs in its own
// mas_lane, and mas_merge adds the offsets and holds the result word. The block takes
// one word per clock while the output is not stalled; the single-port ring in each lane is
// read once per word and written once per sample. A word that gives a result passes
// the sum, divide, scale and calibration-product stages and then the output register.
// After reset or a clear word the first WINDOW samples only fill the rings and give no
// result; every later sample gives one. Clear words and filling samples take no space
// past the sum stage, so they retire from it even while a result waits at the output.
// Calibration registers must be written only while the block is idle.
// Depends on mas_pkg, mas_lane and mas_merge.

module three_channel_moving_average_scaler
  import mas_pkg::*;
#(
  parameter int unsigned WINDOW      = WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration write port
  input  logic                    cfg_we_i,
  input  logic [CIDX_W-1:0]       cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  // Input words
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    command_i,
  input  logic [SAMPLE_BITS-1:0]  sample_inlet_i,
  input  logic [SAMPLE_BITS-1:0]  sample_outlet_i,
  input  logic [SAMPLE_BITS-1:0]  sample_flow_i,
  // Result words
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [AVG_W-1:0]        avg_inlet_o,
  output logic [AVG_W-1:0]        avg_outlet_o,
  output logic [AVG_W-1:0]        avg_flow_o,
  output logic signed [CFG_W-1:0] phys_inlet_o,
  output logic signed [CFG_W-1:0] phys_outlet_o,
  output logic signed [CFG_W-1:0] phys_flow_o
);

  localparam int unsigned PTR_W  = $clog2(WINDOW);
  localparam int unsigned PROD_W = SAMPLE_BITS + CFG_W + 1;
  localparam logic [PTR_W-1:0] SLOT_LAST = PTR_W'(WINDOW - 1);

  logic signed [CFG_W-1:0]  scale_q  [NUM_CH];
  logic signed [CFG_W-1:0]  offset_q [NUM_CH];
  logic [SAMPLE_BITS-1:0]   sample   [NUM_CH];
  logic [SAMPLE_BITS-1:0]   avg      [NUM_CH];
  logic signed [PROD_W-1:0] prod     [NUM_CH];
  logic [AVG_W-1:0]         avg_out  [NUM_CH];
  logic signed [CFG_W-1:0]  phys_out [NUM_CH];

  logic [PTR_W-1:0] slot_q;
  logic             full_q;
  logic             v1_q, clr1_q, res1_q;
  logic             v2_q, v3_q, v4_q;
  logic             acc, is_clr;
  logic             go1, go2, go3, go4;
  logic             rdy1, rdy2, rdy3, rdy4, rdy_out;
  lane_ctrl_t       ctrl;

  // Calibration registers; indexes beyond the map are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CH; c++) begin
        scale_q[c]  <= SCALE_RST;
        offset_q[c] <= OFFSET_RST;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_INLET_SCALE:   scale_q[CH_INLET]   <= cfg_data_i;
        REG_INLET_OFFSET:  offset_q[CH_INLET]  <= cfg_data_i;
        REG_OUTLET_SCALE:  scale_q[CH_OUTLET]  <= cfg_data_i;
        REG_OUTLET_OFFSET: offset_q[CH_OUTLET] <= cfg_data_i;
        REG_FLOW_SCALE:    scale_q[CH_FLOW]    <= cfg_data_i;
        REG_FLOW_OFFSET:   offset_q[CH_FLOW]   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Ready chain: each stage moves when the one after it is empty or moving.
  assign go4  = v4_q && rdy_out;
  assign rdy4 = !v4_q || rdy_out;
  assign go3  = v3_q && rdy4;
  assign rdy3 = !v3_q || rdy4;
  assign go2  = v2_q && rdy3;
  assign rdy2 = !v2_q || rdy3;
  assign go1  = v1_q && (!res1_q || rdy2);
  assign rdy1 = !v1_q || go1;

  assign in_stall_o = !rdy1;
  assign acc        = in_valid_i && rdy1;
  assign is_clr     = (command_i == CMD_CLEAR);

  // Fill tracking: slot pointer and full flag advance on accepted samples; a clear resets both.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      full_q <= 1'b0;
    end else if (acc) begin
      if (is_clr) begin
        slot_q <= '0;
        full_q <= 1'b0;
      end else if (slot_q == SLOT_LAST) begin
        slot_q <= '0;
        full_q <= 1'b1;
      end else begin
        slot_q <= slot_q + 1'b1;
      end
    end
  end

  // Stage valids; only words that give a result go beyond the sum stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      clr1_q <= 1'b0;
      res1_q <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q   <= in_valid_i;
        clr1_q <= is_clr;
        res1_q <= full_q && !is_clr;
      end
      if (rdy2) begin
        v2_q <= go1 && res1_q;
      end
      if (rdy3) begin
        v3_q <= go2;
      end
      if (rdy4) begin
        v4_q <= go3;
      end
    end
  end

  always_comb begin
    ctrl     = '0;
    ctrl.acc = acc;
    ctrl.wr  = acc && !is_clr;
    ctrl.upd = go1;
    ctrl.clr = clr1_q;
    ctrl.sub = res1_q;
    ctrl.ld2 = go1 && res1_q;
    ctrl.ld3 = go2;
    ctrl.ld4 = go3;
  end

  assign sample[CH_INLET]  = sample_inlet_i;
  assign sample[CH_OUTLET] = sample_outlet_i;
  assign sample[CH_FLOW]   = sample_flow_i;

  // One lane per channel, all driven by the same strobes.
  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    mas_lane #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .slot_i   (slot_q),
      .sample_i (sample[c]),
      .scale_i  (scale_q[c]),
      .avg_o    (avg[c]),
      .prod_o   (prod[c])
    );
  end

  // Offset, saturation and the output register.
  mas_merge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ld_i        (go4),
    .out_stall_i (out_stall_i),
    .rdy_o       (rdy_out),
    .avg_i       (avg),
    .prod_i      (prod),
    .offset_i    (offset_q),
    .out_valid_o (out_valid_o),
    .avg_o       (avg_out),
    .phys_o      (phys_out)
  );

  assign avg_inlet_o   = avg_out[CH_INLET];
  assign avg_outlet_o  = avg_out[CH_OUTLET];
  assign avg_flow_o    = avg_out[CH_FLOW];
  assign phys_inlet_o  = phys_out[CH_INLET];
  assign phys_outlet_o = phys_out[CH_OUTLET];
  assign phys_flow_o   = phys_out[CH_FLOW];

  // The input is held off only while the sum stage holds a word it cannot retire.
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> !in_stall_o)
    else $error("input stalled with an empty sum stage");

  // A sample that fills the last slot marks the ring full.
  a_fill_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !is_clr && slot_q == SLOT_LAST) |=> full_q)
    else $error("ring not marked full after its last slot was written");

  // An accepted clear word restarts the fill phase.
  a_clear_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && is_clr) |=> (slot_q == '0 && !full_q))
    else $error("clear word did not restart the fill phase");

  // The full flag drops only because of a clear word.
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(full_q) |-> $past(acc && is_clr))
    else $error("ring left the full state without a clear word");

  // A retiring word that owes a result enters the divide stage.
  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go1 && res1_q) |=> v2_q)
    else $error("result word lost after the sum stage");

endmodule

// ----- bench/mas_check.sv -----
`timescale 1ns / 100ps
// Scoreboard for the three-channel moving-average scaler: it mirrors the ring, the running
// sums and the calibration registers, predicts every result word and compares it on arrival.
// Depends on mas_pkg only.

module mas_check
  import mas_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CIDX_W-1:0]          cfg_index_i,
  input  logic [CFG_W-1:0]           cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic                       command_i,
  input  logic [SAMPLE_BITS_DEF-1:0] sample_inlet_i,
  input  logic [SAMPLE_BITS_DEF-1:0] sample_outlet_i,
  input  logic [SAMPLE_BITS_DEF-1:0] sample_flow_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [AVG_W-1:0]           avg_inlet_i,
  input  logic [AVG_W-1:0]           avg_outlet_i,
  input  logic [AVG_W-1:0]           avg_flow_i,
  input  logic signed [CFG_W-1:0]    phys_inlet_i,
  input  logic signed [CFG_W-1:0]    phys_outlet_i,
  input  logic signed [CFG_W-1:0]    phys_flow_i,
  output int unsigned                mismatches_o,
  output int unsigned                pending_o
);

  localparam int unsigned SUM_W      = SAMPLE_BITS_DEF + $clog2(WINDOW_DEF);
  localparam longint      PHYS_MAX   = 64'sd2147483647;
  localparam longint      PHYS_MIN   = -64'sd2147483648;
  localparam int unsigned MAX_LOGGED = 40;

  // One predicted result word.
  typedef struct {
    logic [AVG_W-1:0]        avg  [NUM_CH];
    logic signed [CFG_W-1:0] phys [NUM_CH];
  } filtered_t;

  filtered_t                  awaiting [$];
  logic [SAMPLE_BITS_DEF-1:0] ring     [NUM_CH][WINDOW_DEF];
  logic [SUM_W-1:0]           run_sum  [NUM_CH];
  int unsigned                slot;
  logic                       filled;
  logic signed [CFG_W-1:0]    gain     [NUM_CH];
  logic signed [CFG_W-1:0]    offset   [NUM_CH];
  int unsigned                errors = 0;

  assign mismatches_o = errors;

  task automatic log_mismatch(input string msg);
    errors++;
    if (errors <= MAX_LOGGED) $display("mas_check: %s at %0t", msg, $time);
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) log_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // Linear calibration in Q16.16, exact in 64 bits, then clipped to 32 signed bits.
  function automatic logic signed [CFG_W-1:0] calibrate(input logic [AVG_W-1:0] avg,
                                                         input logic signed [CFG_W-1:0] g,
                                                         input logic signed [CFG_W-1:0] o);
    longint acc;
    acc = longint'(avg) * longint'(g) + longint'(o);
    if (acc > PHYS_MAX) acc = PHYS_MAX;
    if (acc < PHYS_MIN) acc = PHYS_MIN;
    return CFG_W'(acc);
  endfunction

  // Pushes one sample triple through the ring; returns 1 when it yields a result word.
  function automatic bit filter_word(input logic [SAMPLE_BITS_DEF-1:0] smp [NUM_CH],
                                     output filtered_t res);
    bit was_full;
    was_full = filled;
    for (int c = 0; c < NUM_CH; c++) begin
      if (was_full) run_sum[c] = run_sum[c] - SUM_W'(ring[c][slot]);
      ring[c][slot] = smp[c];
      run_sum[c] = run_sum[c] + SUM_W'(smp[c]);
    end
    if (slot == WINDOW_DEF - 1) begin
      slot = 0;
      filled = 1'b1;
    end else begin
      slot++;
    end
    if (!was_full) return 1'b0;
    for (int c = 0; c < NUM_CH; c++) begin
      res.avg[c]  = AVG_W'(run_sum[c] / WINDOW_DEF);
      res.phys[c] = calibrate(res.avg[c], gain[c], offset[c]);
    end
    return 1'b1;
  endfunction

  // Watch all three ports on every edge; results are retired before new words are predicted.
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    filtered_t                  want;
    logic [SAMPLE_BITS_DEF-1:0] smp [NUM_CH];
    if (!rst_ni) begin
      awaiting.delete();
      for (int c = 0; c < NUM_CH; c++) begin
        run_sum[c] = '0;
        gain[c]    = SCALE_RST;
        offset[c]  = OFFSET_RST;
      end
      slot      = 0;
      filled    = 1'b0;
      pending_o <= 0;
    end else begin
      // Register writes; indexes past the map are dropped.
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_INLET_SCALE:   gain[CH_INLET]    = cfg_data_i;
          REG_INLET_OFFSET:  offset[CH_INLET]  = cfg_data_i;
          REG_OUTLET_SCALE:  gain[CH_OUTLET]   = cfg_data_i;
          REG_OUTLET_OFFSET: offset[CH_OUTLET] = cfg_data_i;
          REG_FLOW_SCALE:    gain[CH_FLOW]     = cfg_data_i;
          REG_FLOW_OFFSET:   offset[CH_FLOW]   = cfg_data_i;
          default: ;
        endcase
      end

      // Compare an accepted result word against the oldest prediction.
      if (out_valid_i && !out_stall_i) begin
        if (awaiting.size() == 0) begin
          log_mismatch("result word arrived with nothing expected");
        end else begin
          want = awaiting.pop_front();
          check_field("avg_inlet", avg_inlet_i, want.avg[CH_INLET]);
          check_field("avg_outlet", avg_outlet_i, want.avg[CH_OUTLET]);
          check_field("avg_flow", avg_flow_i, want.avg[CH_FLOW]);
          check_field("phys_inlet", phys_inlet_i, want.phys[CH_INLET]);
          check_field("phys_outlet", phys_outlet_i, want.phys[CH_OUTLET]);
          check_field("phys_flow", phys_flow_i, want.phys[CH_FLOW]);
        end
      end

      // Predict for an accepted input word. A clear keeps the ring contents.
      if (in_valid_i && !in_stall_i) begin
        if (command_i == CMD_CLEAR) begin
          for (int c = 0; c < NUM_CH; c++) run_sum[c] = '0;
          slot   = 0;
          filled = 1'b0;
        end else begin
          smp[CH_INLET]  = sample_inlet_i;
          smp[CH_OUTLET] = sample_outlet_i;
          smp[CH_FLOW]   = sample_flow_i;
          if (filter_word(smp, want)) awaiting.push_back(want);
        end
      end

      pending_o <= awaiting.size();
    end
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Top of the testbench for three_channel_moving_average_scaler: clock, reset, stimulus,
// receiver stalls and the final verdict. Depends on mas_pkg, the block and mas_check.

module tb;
  import mas_pkg::*;

  localparam int unsigned SB          = SAMPLE_BITS_DEF;
  localparam logic [SB-1:0] SAMPLE_MAX = '1;
  localparam logic [CIDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CIDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int unsigned PHASE_WORDS = 510;
  localparam int unsigned CLEAR_PCT   = 3;
  localparam int unsigned DRAIN       = 20;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CIDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]        cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic                    command;
  logic [SB-1:0]           s_inlet;
  logic [SB-1:0]           s_outlet;
  logic [SB-1:0]           s_flow;
  logic                    out_valid;
  logic                    out_stall;
  logic [AVG_W-1:0]        avg_inlet;
  logic [AVG_W-1:0]        avg_outlet;
  logic [AVG_W-1:0]        avg_flow;
  logic signed [CFG_W-1:0] phys_inlet;
  logic signed [CFG_W-1:0] phys_outlet;
  logic signed [CFG_W-1:0] phys_flow;
  logic                    hold_req;
  int unsigned             mismatches;
  int unsigned             pending;
  int unsigned             tx_gap_pct;
  int unsigned             rx_stall_pct;

  three_channel_moving_average_scaler dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .command_i       (command),
    .sample_inlet_i  (s_inlet),
    .sample_outlet_i (s_outlet),
    .sample_flow_i   (s_flow),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .avg_inlet_o     (avg_inlet),
    .avg_outlet_o    (avg_outlet),
    .avg_flow_o      (avg_flow),
    .phys_inlet_o    (phys_inlet),
    .phys_outlet_o   (phys_outlet),
    .phys_flow_o     (phys_flow)
  );

  mas_check u_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .command_i       (command),
    .sample_inlet_i  (s_inlet),
    .sample_outlet_i (s_outlet),
    .sample_flow_i   (s_flow),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .avg_inlet_i     (avg_inlet),
    .avg_outlet_i    (avg_outlet),
    .avg_flow_i      (avg_flow),
    .phys_inlet_i    (phys_inlet),
    .phys_outlet_i   (phys_outlet),
    .phys_flow_i     (phys_flow),
    .mismatches_o    (mismatches),
    .pending_o       (pending)
  );

  // Free-running 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit; reaching it means the block hung somewhere.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off that lets the pipeline back up.
  initial begin : receiver
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Mostly random codes, with the two extremes showing up often.
  function automatic logic [SB-1:0] pick_sample();
    case ($urandom_range(7))
      0: return '0;
      1: return SAMPLE_MAX;
      default: return SB'($urandom_range(SAMPLE_MAX));
    endcase
  endfunction

  // Offer one word after an optional random gap and hold it until the block takes it.
  task automatic send_word(input logic cmd, input logic [SB-1:0] a, input logic [SB-1:0] b,
                           input logic [SB-1:0] c);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    s_inlet  <= a;
    s_outlet <= b;
    s_flow   <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Long runs of samples broken now and then by a clear, often in the middle of a fill.
  task automatic send_random(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(99) < CLEAR_PCT)
        send_word(CMD_CLEAR, pick_sample(), pick_sample(), pick_sample());
      else
        send_word(CMD_SAMPLE, pick_sample(), pick_sample(), pick_sample());
    end
  endtask

  // Stop offering, wait for every predicted word, then let the pipeline run empty.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Keeps the write enable high across back-to-back writes; the caller lowers it.
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  initial begin : stimulus
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_INLET_SCALE;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    command   <= CMD_SAMPLE;
    s_inlet   <= '0;
    s_outlet  <= '0;
    s_flow    <= '0;
    hold_req  <= 1'b0;
    tx_gap_pct   = 15;
    rx_stall_pct = 61;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset calibration. A full-scale fill gives nothing, the
    // next samples give the first results.
    repeat (WINDOW_DEF) send_word(CMD_SAMPLE, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    send_word(CMD_SAMPLE, '0, '0, '0);
    send_word(CMD_SAMPLE, SAMPLE_MAX, '0, 12'hAAA);
    // A clear with full-scale fields, then a clear in the middle of a fill.
    send_word(CMD_CLEAR, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    repeat (3) send_word(CMD_SAMPLE, '0, SAMPLE_MAX, 12'h001);
    send_word(CMD_CLEAR, '0, '0, '0);
    for (int k = 0; k < WINDOW_DEF; k++)
      send_word(CMD_SAMPLE, (k % 2) ? SAMPLE_MAX : '0, 12'h555, (k % 2) ? '0 : SAMPLE_MAX);
    send_word(CMD_SAMPLE, 12'h555, 12'hAAA, SAMPLE_MAX);
    send_word(CMD_SAMPLE, SAMPLE_MAX, '0, '0);
    settle();

    // Extreme calibration: inlet clips high, outlet clips low, flow is a bare offset.
    write_reg(REG_INLET_SCALE, 32'h7FFF_FFFF);
    write_reg(REG_INLET_OFFSET, 32'h7FFF_FFFF);
    write_reg(REG_OUTLET_SCALE, 32'h8000_0000);
    write_reg(REG_OUTLET_OFFSET, 32'h8000_0000);
    write_reg(REG_FLOW_SCALE, '0);
    write_reg(REG_FLOW_OFFSET, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_A, $urandom);
    cfg_we <= 1'b0;
    send_random(PHASE_WORDS);
    settle();

    // Fully random registers; the sender now idles more than the receiver.
    tx_gap_pct   = 61;
    rx_stall_pct = 15;
    write_reg(REG_INLET_SCALE, $urandom);
    write_reg(REG_INLET_OFFSET, $urandom);
    write_reg(REG_OUTLET_SCALE, $urandom);
    write_reg(REG_OUTLET_OFFSET, $urandom);
    write_reg(REG_FLOW_SCALE, $urandom);
    write_reg(REG_FLOW_OFFSET, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    cfg_we <= 1'b0;
    send_random(PHASE_WORDS);
    settle();

    // Moderate gains that mostly stay in range; no idling, one long receiver hold-off.
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    write_reg(REG_INLET_SCALE, $urandom_range(2 << 20) - (1 << 20));
    write_reg(REG_INLET_OFFSET, $urandom);
    write_reg(REG_OUTLET_SCALE, $urandom_range(2 << 20) - (1 << 20));
    write_reg(REG_OUTLET_OFFSET, $urandom);
    write_reg(REG_FLOW_SCALE, $urandom_range(2 << 20) - (1 << 20));
    write_reg(REG_FLOW_OFFSET, $urandom);
    cfg_we   <= 1'b0;
    hold_req <= 1'b1;
    send_random(PHASE_WORDS);
    settle();

    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
